@@ rtl/ptc_pkg.sv @@
package ptc_pkg;

    localparam int unsigned NS_PER_SECOND = 1000000000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_APPLY,
        ST_HEAD_READ,
        ST_HEAD_CHECK,
        ST_SEND
    } ptc_state_t;

    typedef struct packed {
        logic        operation;
        logic [1:0]  point;
        logic [63:0] stamp_ns;
        logic [31:0] probe_id;
        logic [15:0] probe_len;
        logic [63:0] now_ns;
        logic        sending_done;
    } ptc_item_t;

    typedef struct packed {
        logic        emitted;
        logic [31:0] out_probe_id;
        logic [15:0] out_probe_len;
        logic [63:0] client_send_ns;
        logic [63:0] server_receive_ns;
        logic [63:0] server_send_ns;
        logic [63:0] client_receive_ns;
        logic        complete;
        logic        finished;
        logic        dropped;
    } ptc_result_t;

endpackage

@@ rtl/ptc_front.sv @@
module ptc_front
    import ptc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  ptc_item_t in_item,
    output logic      q_valid,
    input  logic      q_ready,
    output ptc_item_t q_item
);

    ptc_item_t item_reg [2];
    logic      wr_ptr_reg;
    logic      wr_ptr_next;
    logic      rd_ptr_reg;
    logic      rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic      push;
    logic      pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = item_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            item_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("queue count out of range");
    a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2 && !pop) |=> count_reg == 2'd2) else $error("full queue lost item");
    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers out of step");

endmodule

@@ rtl/ptc_back.sv @@
module ptc_back
    import ptc_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  ptc_item_t   q_item,
    input  logic [7:0]  timeout_seconds,
    output logic        res_valid,
    input  logic        res_ready,
    output ptc_result_t res
);

    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [IW-1:0] LAST = IW'(TABLE_DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

    logic [31:0] id_mem   [TABLE_DEPTH];
    logic [15:0] len_mem  [TABLE_DEPTH];
    logic [63:0] add_mem  [TABLE_DEPTH];
    logic [63:0] cs_mem   [TABLE_DEPTH];
    logic [63:0] sr_mem   [TABLE_DEPTH];
    logic [63:0] ss_mem   [TABLE_DEPTH];
    logic [63:0] cr_mem   [TABLE_DEPTH];

    ptc_state_t  state_reg, state_next;
    logic [IW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [IW-1:0] scan_reg, scan_next;
    logic [CW-1:0] count_reg, count_next, seen_reg, seen_next;
    logic [IW-1:0] rd_addr;
    logic [31:0] rd_id_reg;
    logic [15:0] rd_len_reg;
    logic [63:0] rd_add_reg, rd_cs_reg, rd_sr_reg, rd_ss_reg, rd_cr_reg;
    logic        found_reg, found_next;
    logic        dropped_reg, dropped_next;
    logic        res_valid_reg, res_valid_next;
    ptc_result_t res_reg, res_next;
    logic [63:0] limit_reg;
    logic [63:0] age;
    logic        full_stamps;
    logic        wr_en, wr_new;
    logic [IW-1:0] wr_addr;

    function automatic logic [IW-1:0] inc(input logic [IW-1:0] i);
        return (i == LAST) ? '0 : i + 1'b1;
    endfunction

    assign q_ready   = (state_reg == ST_SEND) && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign age         = q_item.now_ns - rd_add_reg;
    assign full_stamps = (rd_cs_reg != 0) && (rd_sr_reg != 0) && (rd_ss_reg != 0)
        && (rd_cr_reg != 0);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        scan_next      = scan_reg;
        count_next     = count_reg;
        seen_next      = seen_reg;
        found_next     = found_reg;
        dropped_next   = dropped_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        rd_addr        = scan_reg;
        wr_en          = 1'b0;
        wr_new         = 1'b0;
        wr_addr        = scan_reg;
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = head_reg;
                if (q_valid)
                begin
                    scan_next    = head_reg;
                    seen_next    = '0;
                    found_next   = 1'b0;
                    dropped_next = 1'b0;
                    state_next   = q_item.operation ? ST_HEAD_READ : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (seen_reg == count_reg)
                begin
                    state_next = ST_APPLY;
                end
                else if (rd_id_reg == q_item.probe_id)
                begin
                    found_next = 1'b1;
                    state_next = ST_APPLY;
                end
                else
                begin
                    scan_next = inc(scan_reg);
                    rd_addr   = inc(scan_reg);
                    seen_next = seen_reg + 1'b1;
                end
            end
            ST_APPLY:
            begin
                if (found_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = scan_reg;
                end
                else if (count_reg < FULL)
                begin
                    wr_en      = 1'b1;
                    wr_new     = 1'b1;
                    wr_addr    = tail_reg;
                    tail_next  = inc(tail_reg);
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    dropped_next = 1'b1;
                end
                state_next = ST_HEAD_READ;
            end
            ST_HEAD_READ:
            begin
                rd_addr    = head_reg;
                state_next = ST_HEAD_CHECK;
            end
            ST_HEAD_CHECK:
            begin
                rd_addr    = head_reg;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                rd_addr = head_reg;
                if (!res_valid_reg || res_ready)
                begin
                    res_next = '0;
                    if (count_reg != '0 && (full_stamps || age > limit_reg))
                    begin
                        res_next.emitted            = 1'b1;
                        res_next.out_probe_id       = rd_id_reg;
                        res_next.out_probe_len      = rd_len_reg;
                        res_next.client_send_ns     = rd_cs_reg;
                        res_next.server_receive_ns  = rd_sr_reg;
                        res_next.server_send_ns     = rd_ss_reg;
                        res_next.client_receive_ns  = rd_cr_reg;
                        res_next.complete           = full_stamps;
                        head_next  = inc(head_reg);
                        count_next = count_reg - 1'b1;
                        res_next.finished = (count_reg == CW'(1)) && q_item.sending_done;
                    end
                    else
                    begin
                        res_next.finished = (count_reg == '0) && q_item.sending_done;
                    end
                    res_next.dropped = dropped_reg;
                    res_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_id_reg  <= id_mem[rd_addr];
        rd_len_reg <= len_mem[rd_addr];
        rd_add_reg <= add_mem[rd_addr];
        rd_cs_reg  <= cs_mem[rd_addr];
        rd_sr_reg  <= sr_mem[rd_addr];
        rd_ss_reg  <= ss_mem[rd_addr];
        rd_cr_reg  <= cr_mem[rd_addr];
        limit_reg  <= 64'(timeout_seconds) * 64'(NS_PER_SECOND);
        if (wr_en)
        begin
            len_mem[wr_addr] <= q_item.probe_len;
            if (wr_new)
            begin
                id_mem[wr_addr]  <= q_item.probe_id;
                add_mem[wr_addr] <= q_item.now_ns;
            end
            if (wr_new || q_item.point == 2'd0)
            begin
                cs_mem[wr_addr] <= (q_item.point == 2'd0) ? q_item.stamp_ns : 64'd0;
            end
            if (wr_new || q_item.point == 2'd1)
            begin
                sr_mem[wr_addr] <= (q_item.point == 2'd1) ? q_item.stamp_ns : 64'd0;
            end
            if (wr_new || q_item.point == 2'd2)
            begin
                ss_mem[wr_addr] <= (q_item.point == 2'd2) ? q_item.stamp_ns : 64'd0;
            end
            if (wr_new || q_item.point == 2'd3)
            begin
                cr_mem[wr_addr] <= (q_item.point == 2'd3) ? q_item.stamp_ns : 64'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg     <= res_next;
        scan_reg    <= scan_next;
        seen_reg    <= seen_next;
        found_reg   <= found_next;
        dropped_reg <= dropped_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL) else $error("entry count above depth");
    a_grow_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPLY && !found_reg && count_reg < FULL) |=>
        count_reg == $past(count_reg) + 1'b1) else $error("append lost");
    a_result_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ready) |=> res_valid_reg && $stable(res_reg))
        else $error("result changed under stall");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && q_valid) |=> state_reg != ST_IDLE)
        else $error("item not taken");

endmodule

@@ rtl/probe_timestamp_collator.sv @@
// Probe timestamp collator.
// Input transactions arrive on in_valid/in_ready and carry one observation or
// a poll. Each one gives exactly one result transaction on out_valid/out_ready,
// in order. A timeout register write uses cfg_valid/cfg_ready and the user
// must make it only while the block is idle; the block does not enforce this.
// A two-entry queue takes inputs while the table engine works; the engine keeps
// its item at the queue head and releases it as its result is registered.
// An observation searches the table one entry a cycle from the oldest, passing
// over at most TABLE_DEPTH entries without a match; a poll goes straight to
// the head read, head check and send steps. The next item starts only after
// the last one's result is registered, so items are handled one at a time,
// paced by the serial search over the table memory.
// Reset empties the table and sets the timeout to 10 seconds; the table
// memories themselves are not cleared.
// When the receiver stalls, the result is held in the output register and
// the engine waits in its final step; the queue takes one more input.
module probe_timestamp_collator
    import ptc_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [1:0]  point,
    input  logic [63:0] stamp_ns,
    input  logic [31:0] probe_id,
    input  logic [15:0] probe_len,
    input  logic [63:0] now_ns,
    input  logic        sending_done,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        emitted,
    output logic [31:0] out_probe_id,
    output logic [15:0] out_probe_len,
    output logic [63:0] client_send_ns,
    output logic [63:0] server_receive_ns,
    output logic [63:0] server_send_ns,
    output logic [63:0] client_receive_ns,
    output logic        complete,
    output logic        finished,
    output logic        dropped
);

    ptc_item_t   in_item;
    ptc_item_t   q_item;
    logic        q_valid;
    logic        q_ready;
    ptc_result_t res;
    logic [7:0]  timeout_reg;

    assign in_item.operation      = operation;
    assign in_item.point          = point;
    assign in_item.stamp_ns       = stamp_ns;
    assign in_item.probe_id       = probe_id;
    assign in_item.probe_len      = probe_len;
    assign in_item.now_ns         = now_ns;
    assign in_item.sending_done   = sending_done;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= 8'd10;
        end
        else if (cfg_valid && cfg_ready)
        begin
            timeout_reg <= cfg_data;
        end
    end

    ptc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    ptc_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_item          (q_item),
        .timeout_seconds (timeout_reg),
        .res_valid       (out_valid),
        .res_ready       (out_ready),
        .res             (res)
    );

    assign emitted            = res.emitted;
    assign out_probe_id       = res.out_probe_id;
    assign out_probe_len      = res.out_probe_len;
    assign client_send_ns     = res.client_send_ns;
    assign server_receive_ns  = res.server_receive_ns;
    assign server_send_ns     = res.server_send_ns;
    assign client_receive_ns  = res.client_receive_ns;
    assign complete           = res.complete;
    assign finished           = res.finished;
    assign dropped            = res.dropped;

endmodule
